>>> rtl/core/assert_macros.svh
// Assertion helpers for the timer queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define CHK_PROP(lbl, clk, rst, prop)
`define CHK_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/dltq_pkg.sv
`timescale 1ns / 1ps
package dltq_pkg;
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_MISS    = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;
   localparam logic [1:0] STS_BAD_TAG = 2'd3;

   typedef struct packed {
      logic [7:0]  tag;
      logic [31:0] delta;
      logic [31:0] period;
      logic        ready;
      logic [31:0] ident;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;
endpackage

>>> rtl/core/dltq_entry_ram.sv
`timescale 1ns / 1ps
module dltq_entry_ram
   import dltq_pkg::*;
(
   input  logic        clock,
   input  ram_req_type req,
   output entry_type   rd_data
);
   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rd_data_ff <= mem[req.raddr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/dltq_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dltq_ctrl
   import dltq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  op,
   input  logic [7:0]  tag,
   input  logic [31:0] delay,
   input  logic [31:0] period,
   input  logic [31:0] target,
   output ram_req_type ram_req,
   input  entry_type   rd,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_id,
   output logic [7:0]  rsp_tag
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_TICK  = 4'd1;
   localparam logic [3:0] ST_WALK  = 4'd2;
   localparam logic [3:0] ST_UP    = 4'd3;
   localparam logic [3:0] ST_NEW   = 4'd4;
   localparam logic [3:0] ST_FIND  = 4'd5;
   localparam logic [3:0] ST_DOWN  = 4'd6;
   localparam logic [3:0] ST_HEAD  = 4'd7;
   localparam logic [3:0] ST_READD = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       tag_ff, tag_in;
   logic [31:0]      delay_ff, delay_in;
   logic [31:0]      period_ff, period_in;
   logic [31:0]      target_ff, target_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      before_ff, before_in;
   logic [32:0]      sum_ff, sum_in;
   logic [31:0]      dsave_ff, dsave_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      last_id_ff, last_id_in;
   logic [7:0]       run_tag_ff, run_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_id_ff, rsp_id_in;
   logic [7:0]       rsp_tag_ff, rsp_tag_in;

   logic [32:0]      walk_sum;
   logic [31:0]      next_id;
   logic [31:0]      rel;
   logic [CNT_W-1:0] k_ext;

   always_comb begin
      walk_sum = {1'b0, before_ff} + {1'b0, rd.delta};
      next_id = last_id_ff + 32'd1;
      if (next_id == 32'd0) begin
         next_id = 32'd1;
      end
      rel = delay_ff - before_ff;
      k_ext = {{(CNT_W-IDX_W){1'b0}}, k_ff};

      state_in = state_ff;
      op_in = op_ff;
      tag_in = tag_ff;
      delay_in = delay_ff;
      period_in = period_ff;
      target_in = target_ff;
      k_in = k_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      before_in = before_ff;
      sum_in = sum_ff;
      dsave_in = dsave_ff;
      cnt_in = cnt_ff;
      last_id_in = last_id_ff;
      run_tag_in = run_tag_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in = rsp_id_ff;
      rsp_tag_in = rsp_tag_ff;
      ram_req = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in = op;
               tag_in = tag;
               delay_in = delay;
               period_in = period;
               target_in = target;
               k_in = '0;
               before_in = '0;
               run_tag_in = '0;
               rsp_status_in = STS_OK;
               rsp_id_in = '0;
               rsp_tag_in = '0;
               case (op)
                  OP_TICK: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_TICK;
                     end
                  end
                  OP_ADD: begin
                     if (tag == 8'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STS_BAD_TAG;
                     end else if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STS_FULL;
                     end else if (cnt_ff == '0) begin
                        pos_in = '0;
                        state_in = ST_NEW;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  OP_DELETE: begin
                     if (target == 32'd0 || cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STS_MISS;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = STS_MISS;
                     end else begin
                        state_in = ST_HEAD;
                     end
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (!rd.ready) begin
               ram_req.we = 1'b1;
               ram_req.waddr = '0;
               ram_req.wdata = rd;
               if (rd.delta != 32'd0) begin
                  ram_req.wdata.delta = rd.delta - 32'd1;
               end
               ram_req.wdata.ready = (rd.delta <= 32'd1);
            end
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (walk_sum > {1'b0, delay_ff}) begin
               pos_in = k_ff;
               sum_in = walk_sum;
               k_in = IDX_W'(cnt_ff);
               ram_req.raddr = IDX_W'(cnt_ff - CNT_W'(1));
               state_in = ST_UP;
            end else begin
               before_in = walk_sum[31:0];
               if (k_ext + CNT_W'(1) == cnt_ff) begin
                  pos_in = IDX_W'(cnt_ff);
                  state_in = ST_NEW;
               end else begin
                  k_in = k_ff + IDX_W'(1);
                  ram_req.raddr = k_ff + IDX_W'(1);
               end
            end
         end
         ST_UP: begin
            ram_req.we = 1'b1;
            ram_req.waddr = k_ff;
            ram_req.wdata = rd;
            if (k_ff == pos_ff + IDX_W'(1)) begin
               ram_req.wdata.delta = 32'(sum_ff - {1'b0, delay_ff});
               ram_req.wdata.ready = 1'b0;
               state_in = ST_NEW;
            end else begin
               k_in = k_ff - IDX_W'(1);
               ram_req.raddr = k_ff - IDX_W'(2);
            end
         end
         ST_NEW: begin
            ram_req.we = 1'b1;
            ram_req.waddr = pos_ff;
            ram_req.wdata.tag = tag_ff;
            ram_req.wdata.delta = rel;
            ram_req.wdata.period = period_ff;
            ram_req.wdata.ready = (rel == 32'd0);
            ram_req.wdata.ident = next_id;
            last_id_in = next_id;
            cnt_in = cnt_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_status_in = STS_OK;
            rsp_id_in = next_id;
            rsp_tag_in = run_tag_ff;
            state_in = ST_IDLE;
         end
         ST_FIND: begin
            if (rd.ident == target_ff) begin
               idx_in = k_ff;
               dsave_in = rd.delta;
               if (k_ext + CNT_W'(1) < cnt_ff) begin
                  ram_req.raddr = k_ff + IDX_W'(1);
                  state_in = ST_DOWN;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (k_ext + CNT_W'(1) == cnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_MISS;
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + IDX_W'(1);
               ram_req.raddr = k_ff + IDX_W'(1);
            end
         end
         ST_HEAD: begin
            if (!rd.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_MISS;
               state_in = ST_IDLE;
            end else begin
               run_tag_in = rd.tag;
               tag_in = rd.tag;
               delay_in = rd.period;
               period_in = rd.period;
               idx_in = '0;
               k_in = '0;
               dsave_in = rd.delta;
               if (cnt_ff > CNT_W'(1)) begin
                  ram_req.raddr = IDX_W'(1);
                  state_in = ST_DOWN;
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  state_in = ST_READD;
               end
            end
         end
         ST_DOWN: begin
            ram_req.we = 1'b1;
            ram_req.waddr = k_ff;
            ram_req.wdata = rd;
            if (k_ff == idx_ff && dsave_ff != 32'd0) begin
               ram_req.wdata.delta = rd.delta + dsave_ff;
               ram_req.wdata.ready = 1'b0;
            end
            if (k_ext + CNT_W'(2) < cnt_ff) begin
               k_in = k_ff + IDX_W'(1);
               ram_req.raddr = k_ff + IDX_W'(2);
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (op_ff == OP_DISPATCH) begin
                  state_in = ST_READD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READD: begin
            k_in = '0;
            before_in = '0;
            if (period_ff == 32'd0) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in = run_tag_ff;
               state_in = ST_IDLE;
            end else if (cnt_ff == '0) begin
               pos_in = '0;
               state_in = ST_NEW;
            end else begin
               state_in = ST_WALK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         last_id_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         last_id_ff <= last_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      tag_ff <= tag_in;
      delay_ff <= delay_in;
      period_ff <= period_in;
      target_ff <= target_in;
      k_ff <= k_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      before_ff <= before_in;
      sum_ff <= sum_in;
      dsave_ff <= dsave_in;
      run_tag_ff <= run_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff <= rsp_id_in;
      rsp_tag_ff <= rsp_tag_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id = rsp_id_ff;
   assign rsp_tag = rsp_tag_ff;

   `CHK_PROP(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(TABLE_DEPTH))
   `CHK_IMPL(a_new_has_room, clock, reset, state_ff == ST_NEW, cnt_ff < CNT_W'(TABLE_DEPTH))
   `CHK_IMPL(a_full_only_when_full, clock, reset, rsp_valid_ff && rsp_status_ff == STS_FULL, cnt_ff == CNT_W'(TABLE_DEPTH))
endmodule

>>> rtl/core/delta_list_task_timer_queue_core.sv
`timescale 1ns / 1ps
// Timer queue holding up to TABLE_DEPTH tasks in a delta list in one entry RAM.
// A command is taken when start is high and busy is low; exactly one result beat
// follows on rsp_valid for one cycle and cannot be held off. A rejected command is
// answered straight from the idle state; a tick and a dispatch first read the head
// entry. Add walks and shifts the RAM at one entry per cycle; delete searches and
// shifts down the entries behind the match; a dispatch removes the ready head and
// re-adds it when it is periodic.
module delta_list_task_timer_queue_core
   import dltq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_task_tag,
   input  logic [31:0] req_start_delay,
   input  logic [31:0] req_repeat_period,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [7:0]  rsp_run_tag
);
   ram_req_type ram_req;
   entry_type   rd_data;

   dltq_entry_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   dltq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .op         (req_opcode),
      .tag        (req_task_tag),
      .delay      (req_start_delay),
      .period     (req_repeat_period),
      .target     (req_target_id),
      .ram_req    (ram_req),
      .rd         (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_id     (rsp_result_id),
      .rsp_tag    (rsp_run_tag)
   );
endmodule
